/* hw/rtl/ial_pkg.sv */
package ial_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned HPOS_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIMIT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT     = 3'd0,
    FN_READ       = 3'd1,
    FN_WRITE      = 3'd2,
    FN_FIND       = 3'd3,
    FN_REMOVE_AT  = 3'd4,
    FN_REMOVE_VAL = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_LAST,
    S_INS_PUT,
    S_RW_RD,
    S_RW_CAP,
    S_RM_RD,
    S_RM_LAST,
    S_FD_RD,
    S_FD_LAST,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_CNT_M1,
    PTR_POS,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_RD
  } ptr_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_VAL,
    WR_UP,
    WR_DOWN
  } wr_op_e;

  typedef struct packed {
    logic    load;
    ptr_op_e ptr_op;
    logic    rd_en;
    wr_op_e  wr_op;
    logic    res_cap;
    logic    hit_cap;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_set;
    status_e st_code;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  pos_gt_cnt;
    logic  pos_ge_cnt;
    logic  full;
    logic  cnt_zero;
    logic  ptr_at_pos;
    logic  ptr_at_last;
    logic  rd_at_pos;
    logic  eq;
  } sts_t;

endpackage

/* hw/rtl/ial_ctrl.sv */
module ial_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  ial_pkg::sts_t sts_i,
  output logic          busy,
  output logic          strobe_o,
  output ial_pkg::cmd_t cmd_o
);

  ial_pkg::state_e state_q, state_d;
  logic            armed_q, armed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ial_pkg::S_IDLE;
      armed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    armed_d       = 1'b0;
    cmd_o         = '0;
    cmd_o.ptr_op  = ial_pkg::PTR_HOLD;
    cmd_o.wr_op   = ial_pkg::WR_NONE;
    cmd_o.st_code = ial_pkg::ST_OK;
    strobe_o      = 1'b0;
    busy          = 1'b1;

    unique case (state_q)
      ial_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ial_pkg::S_DISPATCH;
        end
      end

      ial_pkg::S_DISPATCH: begin
        unique case (sts_i.func)
          ial_pkg::FN_INSERT: begin
            if (sts_i.pos_gt_cnt) begin
              cmd_o.st_set  = 1'b1;
              cmd_o.st_code = ial_pkg::ST_RANGE;
              state_d       = ial_pkg::S_DONE;
            end else if (sts_i.full) begin
              cmd_o.st_set  = 1'b1;
              cmd_o.st_code = ial_pkg::ST_FULL;
              state_d       = ial_pkg::S_DONE;
            end else if (sts_i.pos_ge_cnt) begin
              // append at the end: nothing to move
              state_d = ial_pkg::S_INS_PUT;
            end else begin
              cmd_o.ptr_op = ial_pkg::PTR_CNT_M1;
              state_d      = ial_pkg::S_INS_RD;
            end
          end
          ial_pkg::FN_READ, ial_pkg::FN_WRITE, ial_pkg::FN_REMOVE_AT: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.st_set  = 1'b1;
              cmd_o.st_code = ial_pkg::ST_RANGE;
              state_d       = ial_pkg::S_DONE;
            end else begin
              cmd_o.ptr_op = ial_pkg::PTR_POS;
              state_d      = (sts_i.func == ial_pkg::FN_REMOVE_AT) ?
                             ial_pkg::S_RM_RD : ial_pkg::S_RW_RD;
            end
          end
          ial_pkg::FN_FIND, ial_pkg::FN_REMOVE_VAL: begin
            if (sts_i.cnt_zero) begin
              cmd_o.st_set  = 1'b1;
              cmd_o.st_code = ial_pkg::ST_MISSING;
              state_d       = ial_pkg::S_DONE;
            end else begin
              cmd_o.ptr_op = ial_pkg::PTR_ZERO;
              state_d      = ial_pkg::S_FD_RD;
            end
          end
          default: begin
            state_d = ial_pkg::S_DONE;
          end
        endcase
      end

      // walk down from the last entry, moving each word up by one
      ial_pkg::S_INS_RD: begin
        cmd_o.rd_en = 1'b1;
        armed_d     = 1'b1;
        if (armed_q) begin
          cmd_o.wr_op = ial_pkg::WR_UP;
        end
        if (sts_i.ptr_at_pos) begin
          state_d = ial_pkg::S_INS_LAST;
        end else begin
          cmd_o.ptr_op = ial_pkg::PTR_DEC;
        end
      end

      ial_pkg::S_INS_LAST: begin
        cmd_o.wr_op = ial_pkg::WR_UP;
        state_d     = ial_pkg::S_INS_PUT;
      end

      ial_pkg::S_INS_PUT: begin
        cmd_o.wr_op   = ial_pkg::WR_VAL;
        cmd_o.cnt_inc = 1'b1;
        state_d       = ial_pkg::S_DONE;
      end

      ial_pkg::S_RW_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ial_pkg::S_RW_CAP;
      end

      ial_pkg::S_RW_CAP: begin
        cmd_o.res_cap = 1'b1;
        if (sts_i.func == ial_pkg::FN_WRITE) begin
          cmd_o.wr_op = ial_pkg::WR_VAL;
        end
        state_d = ial_pkg::S_DONE;
      end

      // walk up from the removed entry, moving each later word down by one
      ial_pkg::S_RM_RD: begin
        cmd_o.rd_en = 1'b1;
        armed_d     = 1'b1;
        if (armed_q) begin
          if (sts_i.rd_at_pos) begin
            cmd_o.res_cap = 1'b1;
          end else begin
            cmd_o.wr_op = ial_pkg::WR_DOWN;
          end
        end
        if (sts_i.ptr_at_last) begin
          state_d = ial_pkg::S_RM_LAST;
        end else begin
          cmd_o.ptr_op = ial_pkg::PTR_INC;
        end
      end

      ial_pkg::S_RM_LAST: begin
        if (sts_i.rd_at_pos) begin
          cmd_o.res_cap = 1'b1;
        end else begin
          cmd_o.wr_op = ial_pkg::WR_DOWN;
        end
        cmd_o.cnt_dec = 1'b1;
        state_d       = ial_pkg::S_DONE;
      end

      ial_pkg::S_FD_RD: begin
        cmd_o.rd_en = 1'b1;
        armed_d     = 1'b1;
        if (armed_q && sts_i.eq) begin
          cmd_o.hit_cap = 1'b1;
          armed_d       = 1'b0;
          if (sts_i.func == ial_pkg::FN_FIND) begin
            state_d = ial_pkg::S_DONE;
          end else begin
            cmd_o.ptr_op = ial_pkg::PTR_RD;
            state_d      = ial_pkg::S_RM_RD;
          end
        end else if (sts_i.ptr_at_last) begin
          state_d = ial_pkg::S_FD_LAST;
        end else begin
          cmd_o.ptr_op = ial_pkg::PTR_INC;
        end
      end

      ial_pkg::S_FD_LAST: begin
        if (sts_i.eq) begin
          cmd_o.hit_cap = 1'b1;
          if (sts_i.func == ial_pkg::FN_FIND) begin
            state_d = ial_pkg::S_DONE;
          end else begin
            cmd_o.ptr_op = ial_pkg::PTR_RD;
            state_d      = ial_pkg::S_RM_RD;
          end
        end else begin
          cmd_o.st_set  = 1'b1;
          cmd_o.st_code = ial_pkg::ST_MISSING;
          state_d       = ial_pkg::S_DONE;
        end
      end

      ial_pkg::S_DONE: begin
        strobe_o = 1'b1;
        busy     = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ial_pkg::S_DISPATCH;
        end else begin
          state_d = ial_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ial_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/ial_dpath.sv */
module ial_dpath #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ial_pkg::cmd_t                      cmd_i,
  output ial_pkg::sts_t                      sts_o,
  input  logic                               cfg_valid_i,
  input  logic [ial_pkg::LIMIT_W-1:0]        capacity_limit_i,
  input  logic [ial_pkg::FUNC_W-1:0]         func_i,
  input  logic [ial_pkg::POS_W-1:0]          position_i,
  input  logic signed [ial_pkg::VALUE_W-1:0] item_value_i,
  output logic signed [ial_pkg::VALUE_W-1:0] result_value_o,
  output logic                               hit_o,
  output logic [ial_pkg::HPOS_W-1:0]         hit_position_o,
  output logic [ial_pkg::STATUS_W-1:0]       status_o,
  output logic [ial_pkg::POS_W-1:0]          count_now_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CW > ial_pkg::POS_W) ? CW : ial_pkg::POS_W;
  localparam int unsigned EW    = ELEMENT_WIDTH;

  logic [EW-1:0]                      mem_q [CAPACITY];
  logic [EW-1:0]                      rd_q;
  logic [AW-1:0]                      rd_addr_q;
  logic [AW-1:0]                      ptr_q, ptr_d;
  logic [CW-1:0]                      cnt_q;
  logic [ial_pkg::LIMIT_W-1:0]        limit_q;
  logic [ial_pkg::FUNC_W-1:0]         func_q;
  logic [CMP_W-1:0]                   pos_q;
  logic [EW-1:0]                      val_q;
  logic signed [ial_pkg::VALUE_W-1:0] res_q;
  logic                               hit_q;
  ial_pkg::status_e                   status_q;

  logic signed [63:0] in_wide;
  logic signed [EW-1:0] rd_signed;
  logic signed [63:0] rd_wide;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   lim_eff;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [EW-1:0]      wr_data;

  assign in_wide   = 64'(item_value_i);
  assign rd_signed = rd_q;
  assign rd_wide   = 64'(rd_signed);
  assign cnt_ext   = CMP_W'(cnt_q);
  assign lim_eff   = (CMP_W'(limit_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                          : CMP_W'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ial_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= capacity_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_op)
      ial_pkg::PTR_CNT_M1: ptr_d = AW'(cnt_q - CW'(1));
      ial_pkg::PTR_POS:    ptr_d = pos_q[AW-1:0];
      ial_pkg::PTR_ZERO:   ptr_d = '0;
      ial_pkg::PTR_INC:    ptr_d = ptr_q + AW'(1);
      ial_pkg::PTR_DEC:    ptr_d = ptr_q - AW'(1);
      ial_pkg::PTR_RD:     ptr_d = rd_addr_q;
      default:             ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pos_q[AW-1:0];
    wr_data = val_q;
    case (cmd_i.wr_op)
      ial_pkg::WR_VAL: begin
        wr_addr = pos_q[AW-1:0];
        wr_data = val_q;
      end
      ial_pkg::WR_UP: begin
        wr_addr = rd_addr_q + AW'(1);
        wr_data = rd_q;
      end
      ial_pkg::WR_DOWN: begin
        wr_addr = rd_addr_q - AW'(1);
        wr_data = rd_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // simple dual-port style store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q      <= mem_q[ptr_q];
      rd_addr_q <= ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      func_q   <= func_i;
      pos_q    <= CMP_W'(position_i);
      val_q    <= in_wide[EW-1:0];
      res_q    <= '0;
      hit_q    <= 1'b0;
      status_q <= ial_pkg::ST_OK;
    end else begin
      if (cmd_i.res_cap) begin
        res_q <= rd_wide[ial_pkg::VALUE_W-1:0];
      end
      if (cmd_i.hit_cap) begin
        hit_q <= 1'b1;
        pos_q <= CMP_W'(rd_addr_q);
      end
      if (cmd_i.st_set) begin
        status_q <= cmd_i.st_code;
      end
    end
  end

  always_comb begin
    sts_o.func        = ial_pkg::func_e'(func_q);
    sts_o.pos_gt_cnt  = pos_q > cnt_ext;
    sts_o.pos_ge_cnt  = pos_q >= cnt_ext;
    sts_o.full        = cnt_ext >= lim_eff;
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.ptr_at_pos  = (CMP_W'(ptr_q) == pos_q);
    sts_o.ptr_at_last = (CW'(ptr_q) == (cnt_q - CW'(1)));
    sts_o.rd_at_pos   = (CMP_W'(rd_addr_q) == pos_q);
    sts_o.eq          = (rd_q == val_q);
  end

  assign result_value_o = res_q;
  assign hit_o          = hit_q;
  assign hit_position_o = hit_q ? pos_q[ial_pkg::HPOS_W-1:0] : '0;
  assign status_o       = status_q;
  assign count_now_o    = ial_pkg::POS_W'(cnt_q);

endmodule

/* hw/rtl/indexed_array_list_engine_top.sv */
// Ordered array list of CAPACITY entries held in one memory with one write and
// one registered read per cycle. A request is taken when start is high and busy
// is low; its single result word appears for exactly one cycle with strobe_o and
// must be taken then, as the block never waits for the receiver. A rejected or
// unused request, read, write, insert at the end and a search of an empty list
// walk no entries; insert elsewhere walks down from the last entry to the
// position, remove_at walks up from the position to the last entry, find walks
// up from position 0 to the first match or the last entry, and remove_value
// does the same and on a hit then walks up from the match to the last entry.
// The walk of the memory port moves one entry per cycle. A new request can
// be accepted in the strobe cycle. The capacity limit may be written at any time
// the block is idle; entries of the store are only ever read once written.
module indexed_array_list_engine_top #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ial_pkg::FUNC_W-1:0]         func_i,
  input  logic [ial_pkg::POS_W-1:0]          position_i,
  input  logic signed [ial_pkg::VALUE_W-1:0] item_value_i,
  output logic                               strobe_o,
  output logic signed [ial_pkg::VALUE_W-1:0] result_value_o,
  output logic                               hit_o,
  output logic [ial_pkg::HPOS_W-1:0]         hit_position_o,
  output logic [ial_pkg::STATUS_W-1:0]       status_o,
  output logic [ial_pkg::POS_W-1:0]          count_now_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ial_pkg::LIMIT_W-1:0]        capacity_limit_i
);

  ial_pkg::cmd_t cmd;
  ial_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ial_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .sts_i    (sts),
    .busy     (busy),
    .strobe_o (strobe_o),
    .cmd_o    (cmd)
  );

  ial_dpath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .capacity_limit_i (capacity_limit_i),
    .func_i           (func_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .result_value_o   (result_value_o),
    .hit_o            (hit_o),
    .hit_position_o   (hit_position_o),
    .status_o         (status_o),
    .count_now_o      (count_now_o)
  );

endmodule

/* hw/rtl/ial_checker.sv */
module ial_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               strobe_o,
  input logic signed [ial_pkg::VALUE_W-1:0] result_value_o,
  input logic                               hit_o,
  input logic [ial_pkg::STATUS_W-1:0]       status_o
);

  // a taken request keeps the block busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a request");

  // a result is never shown while the block claims to be busy
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("strobe while busy");

  // no strobe in the cycle right after a request is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !strobe_o)
    else $error("result strobed one cycle after acceptance");

  // a hit only comes with an ok status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && hit_o) |-> (status_o == ial_pkg::ST_OK))
    else $error("hit reported with an error status");

  // any error word carries a zero value and no hit
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (status_o != ial_pkg::ST_OK)) |-> (!hit_o && (result_value_o == '0)))
    else $error("error word carries data");

endmodule

bind indexed_array_list_engine_top ial_checker u_ial_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .strobe_o       (strobe_o),
  .result_value_o (result_value_o),
  .hit_o          (hit_o),
  .status_o       (status_o)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * LIST_DEPTH + 20;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned PHASES       = 8;

  // func codes the block leaves unused
  localparam logic [ial_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [ial_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  // values that repeat often, so searches find duplicates and hit the first one
  localparam logic [ial_pkg::VALUE_W-1:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'hA5A5_5A5A
  };

  typedef struct packed {
    logic [ial_pkg::VALUE_W-1:0]  value;
    logic                         hit;
    logic [ial_pkg::HPOS_W-1:0]   hpos;
    logic [ial_pkg::STATUS_W-1:0] status;
    logic [ial_pkg::POS_W-1:0]    count;
  } reply_t;

  class list_mirror_t;
    logic [ial_pkg::VALUE_W-1:0] entries [LIST_DEPTH];
    int unsigned used;
    int unsigned limit;
    reply_t      awaited_q [$];
    int unsigned faults, requests, replies, hits, misses, range_errs, full_errs, peak;

    function new();
      used = 0;
      limit = 32'(ial_pkg::LIMIT_RESET);
      faults = 0;
      requests = 0;
      replies = 0;
      hits = 0;
      misses = 0;
      range_errs = 0;
      full_errs = 0;
      peak = 0;
    endfunction

    function logic [ial_pkg::VALUE_W-1:0] take_out(int unsigned at);
      logic [ial_pkg::VALUE_W-1:0] v;
      v = entries[at];
      for (int unsigned i = at + 1; i < used; i++) entries[i-1] = entries[i];
      used--;
      return v;
    endfunction

    function void note_request(logic [ial_pkg::FUNC_W-1:0] fn, logic [ial_pkg::POS_W-1:0] pos,
                               logic [ial_pkg::VALUE_W-1:0] val);
      reply_t r;
      int unsigned cap;
      int found;
      r = '0;
      found = -1;
      cap = (limit > LIST_DEPTH) ? LIST_DEPTH : limit;
      case (fn)
        ial_pkg::FN_INSERT: begin
          // range check takes priority over full
          if (pos > used) r.status = ial_pkg::ST_RANGE;
          else if (used >= cap) r.status = ial_pkg::ST_FULL;
          else begin
            for (int unsigned i = used; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            used++;
          end
        end
        ial_pkg::FN_READ, ial_pkg::FN_WRITE, ial_pkg::FN_REMOVE_AT: begin
          if (pos >= used) r.status = ial_pkg::ST_RANGE;
          else if (fn == ial_pkg::FN_REMOVE_AT) r.value = take_out(32'(pos));
          else begin
            r.value = entries[pos];
            if (fn == ial_pkg::FN_WRITE) entries[pos] = val;
          end
        end
        ial_pkg::FN_FIND, ial_pkg::FN_REMOVE_VAL: begin
          for (int i = 0; i < int'(used); i++)
            if (found < 0 && entries[i] == val) found = i;
          if (found < 0) r.status = ial_pkg::ST_MISSING;
          else begin
            r.hit = 1'b1;
            r.hpos = found[ial_pkg::HPOS_W-1:0];
            if (fn == ial_pkg::FN_REMOVE_VAL) r.value = take_out(unsigned'(found));
          end
        end
        default: ;
      endcase
      r.count = used[ial_pkg::POS_W-1:0];
      requests++;
      if (r.hit) hits++;
      if (r.status == ial_pkg::ST_MISSING) misses++;
      if (r.status == ial_pkg::ST_RANGE) range_errs++;
      if (r.status == ial_pkg::ST_FULL) full_errs++;
      if (used > peak) peak = used;
      awaited_q.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited_q.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("unexpected result word: value %h hit %b pos %0d status %0d count %0d",
                   got.value, got.hit, got.hpos, got.status, got.count);
        return;
      end
      want = awaited_q.pop_front();
      replies++;
      if (got.value !== want.value || got.hit !== want.hit || got.hpos !== want.hpos ||
          got.status !== want.status || got.count !== want.count) begin
        faults++;
        if (faults <= REPORT_MAX) begin
          $display("result %0d wrong: expected value %h hit %b pos %0d status %0d count %0d",
                   replies, want.value, want.hit, want.hpos, want.status, want.count);
          $display("  got value %h hit %b pos %0d status %0d count %0d",
                   got.value, got.hit, got.hpos, got.status, got.count);
        end
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [ial_pkg::FUNC_W-1:0]   func_i;
  logic [ial_pkg::POS_W-1:0]    position_i;
  logic [ial_pkg::VALUE_W-1:0]  item_value_i;
  logic                         strobe_o;
  logic [ial_pkg::VALUE_W-1:0]  result_value_o;
  logic                         hit_o;
  logic [ial_pkg::HPOS_W-1:0]   hit_position_o;
  logic [ial_pkg::STATUS_W-1:0] status_o;
  logic [ial_pkg::POS_W-1:0]    count_now_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [ial_pkg::LIMIT_W-1:0]  capacity_limit_i;

  list_mirror_t mirror = new();
  int unsigned  stall_cycles = 0;
  bit           quiet = 1'b0;

  indexed_array_list_engine_top #(
    .CAPACITY      (LIST_DEPTH),
    .ELEMENT_WIDTH (ial_pkg::VALUE_W)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .strobe_o         (strobe_o),
    .result_value_o   (result_value_o),
    .hit_o            (hit_o),
    .hit_position_o   (hit_position_o),
    .status_o         (status_o),
    .count_now_o      (count_now_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .capacity_limit_i (capacity_limit_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // check the outgoing word before noting a request taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o)
        mirror.check_reply({result_value_o, hit_o, hit_position_o, status_o, count_now_o});
      if (start && !busy) mirror.note_request(func_i, position_i, item_value_i);
      if (cfg_valid_i && cfg_ready_o) mirror.limit = 32'(capacity_limit_i);
    end
    if ((start && !busy) || strobe_o || (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic submit(input logic [ial_pkg::FUNC_W-1:0] fn,
                        input logic [ial_pkg::POS_W-1:0] pos,
                        input logic [ial_pkg::VALUE_W-1:0] val);
    int unsigned gap;
    int unsigned r;
    start <= 1'b1;
    func_i <= fn;
    position_i <= pos;
    item_value_i <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = $urandom_range(0, 99);
    if (quiet || r < 50) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // write the limit only once every outstanding word has come back
  task automatic set_limit(input logic [ial_pkg::LIMIT_W-1:0] lim);
    start <= 1'b0;
    @(posedge clk_i);
    while (mirror.awaited_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    capacity_limit_i <= lim;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_request(input int unsigned target);
    logic [ial_pkg::FUNC_W-1:0]  fn;
    logic [ial_pkg::POS_W-1:0]   pos;
    logic [ial_pkg::VALUE_W-1:0] val;
    int unsigned r, n;
    n = mirror.used;
    r = $urandom_range(0, 99);
    // lean towards inserts while below the target fill, towards removes above it
    if (r < ((n < target) ? 55 : 15)) fn = ial_pkg::FN_INSERT;
    else if (r < 70)
      fn = (r % 3 == 0) ? ial_pkg::FN_READ : (r % 3 == 1) ? ial_pkg::FN_WRITE : ial_pkg::FN_FIND;
    else if (r < 96) fn = r[0] ? ial_pkg::FN_REMOVE_AT : ial_pkg::FN_REMOVE_VAL;
    else fn = (r < 98) ? FN_SPARE_6 : FN_SPARE_7;
    case ($urandom_range(0, 9))
      0: pos = 7'($urandom_range(0, 127));
      1: pos = (n == 0) ? '0 : 7'(n - 1);
      2: pos = '0;
      default: pos = 7'($urandom_range(0, n));
    endcase
    if ((fn == ial_pkg::FN_FIND || fn == ial_pkg::FN_REMOVE_VAL) && n != 0 &&
        $urandom_range(0, 9) < 7)
      val = mirror.entries[$urandom_range(0, n - 1)];
    else if ($urandom_range(0, 9) < 4) val = VALUE_POOL[$urandom_range(0, 7)];
    else val = $urandom;
    submit(fn, pos, val);
  endtask

  initial begin
    logic [ial_pkg::LIMIT_W-1:0] phase_limit [PHASES];
    int unsigned                 phase_items [PHASES];
    int unsigned                 target;
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = '0;
    position_i = '0;
    item_value_i = '0;
    cfg_valid_i = 1'b0;
    capacity_limit_i = ial_pkg::LIMIT_RESET;
    phase_limit = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd33, 7'($urandom_range(3, 63)),
                    7'($urandom_range(2, 63)), 7'd64};
    phase_items = '{220, 120, 80, 60, 120, 120, 120, 110};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_limit(ial_pkg::LIMIT_RESET);

    // empty list: every access out of range, every search missing
    submit(ial_pkg::FN_READ, 7'd0, 32'h0);
    submit(ial_pkg::FN_REMOVE_AT, 7'd0, 32'h0);
    submit(ial_pkg::FN_FIND, 7'd0, 32'h0);
    submit(ial_pkg::FN_REMOVE_VAL, 7'd0, 32'hFFFF_FFFF);
    submit(ial_pkg::FN_INSERT, 7'd1, 32'h1234_5678);
    // build a short list with the value extremes and a duplicate
    submit(ial_pkg::FN_INSERT, 7'd0, 32'h7FFF_FFFF);
    submit(ial_pkg::FN_INSERT, 7'd0, 32'h8000_0000);
    submit(ial_pkg::FN_INSERT, 7'd2, 32'hFFFF_FFFF);
    submit(ial_pkg::FN_INSERT, 7'd1, 32'h0000_0000);
    submit(ial_pkg::FN_INSERT, 7'd4, 32'hFFFF_FFFF);
    submit(ial_pkg::FN_READ, 7'd3, 32'h0);
    submit(ial_pkg::FN_WRITE, 7'd0, 32'h5555_5555);
    submit(ial_pkg::FN_WRITE, 7'd127, 32'hAAAA_AAAA);
    submit(ial_pkg::FN_READ, 7'd5, 32'h0);
    submit(ial_pkg::FN_FIND, 7'd0, 32'hFFFF_FFFF);
    submit(ial_pkg::FN_FIND, 7'd0, 32'hAAAA_AAAA);
    submit(ial_pkg::FN_REMOVE_VAL, 7'd0, 32'hFFFF_FFFF);
    submit(ial_pkg::FN_REMOVE_AT, 7'd0, 32'h0);
    submit(ial_pkg::FN_REMOVE_AT, 7'd3, 32'h0);
    submit(FN_SPARE_6, 7'd127, 32'hFFFF_FFFF);
    submit(FN_SPARE_7, 7'd0, 32'h0);
    submit(ial_pkg::FN_INSERT, 7'd127, 32'h0);
    // drop the limit under the current count: inserts full, the rest still works
    set_limit(7'd2);
    submit(ial_pkg::FN_INSERT, 7'd0, 32'h1);
    submit(ial_pkg::FN_READ, 7'd1, 32'h0);
    submit(ial_pkg::FN_REMOVE_VAL, 7'd0, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      set_limit(phase_limit[p]);
      target = 0;
      for (int i = 0; i < int'(phase_items[p]); i++) begin
        if (i % 30 == 0) begin
          case ($urandom_range(0, 3))
            0: target = 0;
            1: target = LIST_DEPTH;
            default: target = $urandom_range(1, LIST_DEPTH - 1);
          endcase
          quiet = ($urandom_range(0, 3) == 0);
        end
        random_request(target);
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (mirror.awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests and checked %0d result words: %0d hits, %0d not found,",
             mirror.requests, mirror.replies, mirror.hits, mirror.misses);
    $display("%0d out of range, %0d full; limits 0 to 127 tried, list reached %0d entries.",
             mirror.range_errs, mirror.full_errs, mirror.peak);
    if (mirror.faults == 0 && mirror.awaited_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ial_pkg.sv
hw/rtl/ial_ctrl.sv
hw/rtl/ial_dpath.sv
hw/rtl/indexed_array_list_engine_top.sv
hw/rtl/ial_checker.sv
sim/testbench.sv
